// File: rtl/fbam_pkg.sv
// ----------------------------------------------------------------------------
// fbam_pkg - shared types and codes of the flash block allocator map
// Request and status codes, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package fbam_pkg;

	// Request kinds carried on the input beat.
	typedef enum logic [1:0] {
		REQ_ALLOC     = 2'd0,
		REQ_RETURN    = 2'd1,
		REQ_TRANSLATE = 2'd2,
		REQ_NONE      = 2'd3
	} req_t;

	// Result status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BLOCK_RANGE = 3'd1;
	localparam logic [2:0] ST_VOL_RANGE   = 3'd2;
	localparam logic [2:0] ST_UNIT_RANGE  = 3'd3;
	localparam logic [2:0] ST_NO_FREE     = 3'd4;
	localparam logic [2:0] ST_NOT_ALLOC   = 3'd5;

	// Configuration register indexes.
	localparam logic [1:0] REG_VOLUMES  = 2'd0;
	localparam logic [1:0] REG_CHANNELS = 2'd1;
	localparam logic [1:0] REG_CHIPS    = 2'd2;
	localparam logic [1:0] REG_BLOCKS   = 2'd3;

	// Sequencer states.
	typedef enum logic [7:0] {
		S_CLEAR  = 8'b0000_0001,
		S_IDLE   = 8'b0000_0010,
		S_CHECK  = 8'b0000_0100,
		S_MAPRD  = 8'b0000_1000,
		S_USEDRD = 8'b0001_0000,
		S_CURRD  = 8'b0010_0000,
		S_SCAN   = 8'b0100_0000,
		S_DONE   = 8'b1000_0000
	} state_t;

endpackage

`default_nettype wire

// File: rtl/fbam_ram.sv
// ----------------------------------------------------------------------------
// fbam_ram - generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fbam_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr,
	input  wire logic [Width-1:0]                       wdata,
	input  wire logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr,
	output logic      [Width-1:0]                       rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/flash_block_allocator_map.sv
// ----------------------------------------------------------------------------
// flash_block_allocator_map - virtual to physical flash block allocator
// Next-fit block allocation per chip with a per-volume block map.
// ----------------------------------------------------------------------------
// Each beat on the input asks to allocate, return or translate the virtual
// block of one volume on one channel and chip, and yields exactly one result
// beat carrying a status and a physical block number. After reset the block
// first sweeps its memories clear, one entry per cycle, over all
// MAX_VOLUMES*MAX_CHANNELS*MAX_CHIPS*MAX_BLOCKS entries (65536 at the default
// sizes); it takes no request beat until the sweep is over, although
// configuration writes are taken throughout. A request is then accepted only
// while the sequencer is idle. An undefined or rejected request goes from
// the check straight to the result; translate reads the map; return reads
// the map and then the used flag (skipping the flag when the stored block
// lies beyond blocks_in_use); allocate reads the chip's cursor and then
// searches for a free block: the search reads one used flag per cycle from
// the block status memory, starting at the chip's cursor and wrapping at
// blocks_in_use. Once its result is placed, the sequencer returns to idle;
// it takes no request until it is through with the last. A finished result
// sits in the output register while the next request is accepted; the
// sequencer only waits for that register when it has a further result to
// place there.
// ----------------------------------------------------------------------------
`default_nettype none

module flash_block_allocator_map #(
	parameter int MAX_VOLUMES  = 4,
	parameter int MAX_CHANNELS = 8,
	parameter int MAX_CHIPS    = 8,
	parameter int MAX_BLOCKS   = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Request stream.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // volume[1:0], channel[4:2], chip[7:5], block_index[15:8]
	input  wire logic [1:0]  s_tuser,   // req_type[1:0]
	// Result stream.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // phys_block[7:0]
	output logic [2:0]       m_tuser,   // status[2:0]
	// Configuration writes.
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data
);

	localparam int UNITS      = MAX_CHANNELS * MAX_CHIPS;
	localparam int PHYS_DEPTH = UNITS * MAX_BLOCKS;
	localparam int VIRT_DEPTH = MAX_VOLUMES * PHYS_DEPTH;
	localparam int BW         = $clog2(MAX_BLOCKS);          // stored block number
	localparam int CW         = $clog2(MAX_BLOCKS + 1);      // block count
	localparam int UA         = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int PA         = $clog2(PHYS_DEPTH);
	localparam int VA         = $clog2(VIRT_DEPTH);

	// Configuration registers.
	logic [2:0] vols_q;
	logic [3:0] chans_q;
	logic [3:0] chips_q;
	logic [8:0] blocks_q;

	// Request held for the duration of its processing.
	fbam_pkg::req_t req_q;
	logic [1:0]     vol_q;
	logic [2:0]     ch_q;
	logic [2:0]     cp_q;
	logic [7:0]     blk_q;

	fbam_pkg::state_t state_q;
	logic [VA-1:0]    clr_q;
	logic [BW-1:0]    cur_q;
	logic [BW-1:0]    ret_q;
	logic [CW-1:0]    tries_q;
	logic [2:0]       res_status_q;
	logic [7:0]       res_phys_q;

	logic       m_tvalid_q;
	logic [7:0] m_tdata_q;
	logic [2:0] m_tuser_q;

	// Memory ports.
	logic          map_we;
	logic [VA-1:0] map_waddr;
	logic [BW-1:0] map_wdata;
	logic [VA-1:0] map_raddr;
	logic [BW-1:0] map_rdata;
	logic          used_we;
	logic [PA-1:0] used_waddr;
	logic          used_wdata;
	logic [PA-1:0] used_raddr;
	logic          used_rdata;
	logic          cur_we;
	logic [UA-1:0] cur_waddr;
	logic [BW-1:0] cur_wdata;
	logic [UA-1:0] cur_raddr;
	logic [BW-1:0] cur_rdata;

	// Derived values.
	logic [CW-1:0] nblk;
	logic          blk_bad;
	logic          vol_bad;
	logic          unit_bad;
	logic [UA-1:0] unit;
	logic [PA-1:0] pbase;
	logic [VA-1:0] vidx;
	logic [BW-1:0] cur_start;
	logic [BW-1:0] cur_next;
	logic          scan_last;
	logic [BW-1:0] used_sel;
	logic          clearing;
	logic          res_free;

	// Counts in use are the register values limited by the sizes built in.
	always_comb begin
		nblk = (int'(blocks_q) < MAX_BLOCKS) ? CW'(blocks_q) : CW'(MAX_BLOCKS);
		blk_bad  = int'(blk_q) >= int'(nblk);
		vol_bad  = (int'(vol_q) >= int'(vols_q)) || (int'(vol_q) >= MAX_VOLUMES);
		unit_bad = (int'(ch_q) >= int'(chans_q)) || (int'(ch_q) >= MAX_CHANNELS) ||
		           (int'(cp_q) >= int'(chips_q)) || (int'(cp_q) >= MAX_CHIPS);
	end

	// Addresses of the request in each memory; constant multipliers only.
	always_comb begin
		unit  = UA'(int'(ch_q) * MAX_CHIPS + int'(cp_q));
		pbase = PA'((int'(ch_q) * MAX_CHIPS + int'(cp_q)) * MAX_BLOCKS);
		vidx  = VA'(((int'(vol_q) * MAX_CHANNELS + int'(ch_q)) * MAX_CHIPS + int'(cp_q))
		            * MAX_BLOCKS + int'(blk_q));
	end

	// A cursor left beyond a shrunken wrap point restarts at block 0.
	always_comb begin
		cur_start = (int'(cur_rdata) >= int'(nblk)) ? '0 : cur_rdata;
		cur_next  = (int'(cur_q) + 1 == int'(nblk)) ? '0 : cur_q + 1'b1;
		scan_last = (int'(tries_q) + 1 == int'(nblk));
	end

	assign clearing = (state_q == fbam_pkg::S_CLEAR);
	assign res_free = !m_tvalid_q || m_tready;

	// Memory port control.
	always_comb begin
		unique case (state_q)
			fbam_pkg::S_CURRD: used_sel = cur_start;
			fbam_pkg::S_SCAN:  used_sel = cur_next;
			default:           used_sel = map_rdata;
		endcase

		map_raddr  = vidx;
		cur_raddr  = unit;
		used_raddr = pbase + PA'(used_sel);

		map_we    = clearing ||
		            (state_q == fbam_pkg::S_SCAN && !used_rdata) ||
		            (state_q == fbam_pkg::S_MAPRD && req_q == fbam_pkg::REQ_RETURN);
		map_waddr = clearing ? clr_q : vidx;
		map_wdata = (state_q == fbam_pkg::S_SCAN) ? cur_q : '0;

		used_we    = (clearing && int'(clr_q) < PHYS_DEPTH) ||
		             (state_q == fbam_pkg::S_SCAN && !used_rdata) ||
		             (state_q == fbam_pkg::S_USEDRD && used_rdata);
		used_waddr = clearing ? clr_q[PA-1:0] :
		             (state_q == fbam_pkg::S_SCAN) ? pbase + PA'(cur_q) : pbase + PA'(ret_q);
		used_wdata = (state_q == fbam_pkg::S_SCAN);

		cur_we    = (clearing && int'(clr_q) < UNITS) ||
		            (state_q == fbam_pkg::S_SCAN && (!used_rdata || scan_last));
		cur_waddr = clearing ? clr_q[UA-1:0] : unit;
		cur_wdata = clearing ? '0 : (used_rdata ? cur_next : cur_q);
	end

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vols_q   <= 3'd4;
			chans_q  <= 4'd8;
			chips_q  <= 4'd8;
			blocks_q <= 9'd256;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fbam_pkg::REG_VOLUMES:  vols_q   <= cfg_data[2:0];
				fbam_pkg::REG_CHANNELS: chans_q  <= cfg_data[3:0];
				fbam_pkg::REG_CHIPS:    chips_q  <= cfg_data[3:0];
				fbam_pkg::REG_BLOCKS:   blocks_q <= cfg_data;
			endcase
		end
	end

	assign s_tready = (state_q == fbam_pkg::S_IDLE);

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbam_pkg::S_CLEAR;
			clr_q   <= '0;
		end else begin
			unique case (state_q)
				fbam_pkg::S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (int'(clr_q) == VIRT_DEPTH - 1) begin
						state_q <= fbam_pkg::S_IDLE;
					end
				end
				fbam_pkg::S_IDLE: begin
					if (s_tvalid) begin
						state_q <= fbam_pkg::S_CHECK;
					end
				end
				fbam_pkg::S_CHECK: begin
					if (req_q == fbam_pkg::REQ_NONE || blk_bad || vol_bad || unit_bad) begin
						state_q <= fbam_pkg::S_DONE;
					end else if (req_q == fbam_pkg::REQ_ALLOC) begin
						state_q <= fbam_pkg::S_CURRD;
					end else begin
						state_q <= fbam_pkg::S_MAPRD;
					end
				end
				fbam_pkg::S_MAPRD: begin
					if (req_q == fbam_pkg::REQ_RETURN && int'(map_rdata) < int'(nblk)) begin
						state_q <= fbam_pkg::S_USEDRD;
					end else begin
						state_q <= fbam_pkg::S_DONE;
					end
				end
				fbam_pkg::S_USEDRD: state_q <= fbam_pkg::S_DONE;
				fbam_pkg::S_CURRD:  state_q <= fbam_pkg::S_SCAN;
				fbam_pkg::S_SCAN: begin
					if (!used_rdata || scan_last) begin
						state_q <= fbam_pkg::S_DONE;
					end
				end
				fbam_pkg::S_DONE: begin
					if (res_free) begin
						state_q <= fbam_pkg::S_IDLE;
					end
				end
				default: state_q <= fbam_pkg::S_IDLE;
			endcase
		end
	end

	// Request fields, search position and the pending result.
	always_ff @(posedge clk) begin
		unique case (state_q)
			fbam_pkg::S_IDLE: begin
				req_q <= fbam_pkg::req_t'(s_tuser);
				vol_q <= s_tdata[1:0];
				ch_q  <= s_tdata[4:2];
				cp_q  <= s_tdata[7:5];
				blk_q <= s_tdata[15:8];
			end
			fbam_pkg::S_CHECK: begin
				res_phys_q <= '0;
				if (req_q == fbam_pkg::REQ_NONE) begin
					res_status_q <= fbam_pkg::ST_OK;
				end else if (blk_bad) begin
					res_status_q <= fbam_pkg::ST_BLOCK_RANGE;
				end else if (vol_bad) begin
					res_status_q <= fbam_pkg::ST_VOL_RANGE;
				end else if (unit_bad) begin
					res_status_q <= fbam_pkg::ST_UNIT_RANGE;
				end else begin
					res_status_q <= fbam_pkg::ST_OK;
				end
			end
			fbam_pkg::S_MAPRD: begin
				ret_q <= map_rdata;
				if (req_q == fbam_pkg::REQ_TRANSLATE) begin
					res_phys_q <= 8'(map_rdata);
				end else if (int'(map_rdata) >= int'(nblk)) begin
					res_status_q <= fbam_pkg::ST_NOT_ALLOC;
				end
			end
			fbam_pkg::S_USEDRD: begin
				if (!used_rdata) begin
					res_status_q <= fbam_pkg::ST_NOT_ALLOC;
				end
			end
			fbam_pkg::S_CURRD: begin
				cur_q   <= cur_start;
				tries_q <= '0;
			end
			fbam_pkg::S_SCAN: begin
				if (!used_rdata) begin
					res_phys_q <= 8'(cur_q);
				end else if (scan_last) begin
					res_status_q <= fbam_pkg::ST_NO_FREE;
				end else begin
					cur_q   <= cur_next;
					tries_q <= tries_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: holds one result while the next request is worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == fbam_pkg::S_DONE && res_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fbam_pkg::S_DONE && res_free) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= res_phys_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// Virtual block map, one entry per volume, unit and virtual block.
	fbam_ram #(
		.Width(BW),
		.Depth(VIRT_DEPTH)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	// Used flag of every physical block.
	fbam_ram #(
		.Width(1),
		.Depth(PHYS_DEPTH)
	) u_used_ram (
		.clk  (clk),
		.we   (used_we),
		.waddr(used_waddr),
		.wdata(used_wdata),
		.raddr(used_raddr),
		.rdata(used_rdata)
	);

	// Next-fit search cursor of every chip.
	fbam_ram #(
		.Width(BW),
		.Depth(UNITS)
	) u_cursor_ram (
		.clk  (clk),
		.we   (cur_we),
		.waddr(cur_waddr),
		.wdata(cur_wdata),
		.raddr(cur_raddr),
		.rdata(cur_rdata)
	);

endmodule

`default_nettype wire
